@@ hw/rtl/bhx_pkg.sv @@
// Shared types, constants and functions of the BinHex 4.0 stream decoder.
package bhx_pkg;

	localparam logic [7:0] RUN_MARK  = 8'h90;
	localparam logic [7:0] CODE_DONE = 8'h7F;
	localparam logic [7:0] CODE_SKIP = 8'h7E;
	localparam logic [7:0] CODE_FAIL = 8'h7D;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam int INFO_LEN = 20;
	localparam int MAX_RES = 4;
	localparam logic [31:0] TEXT_TYPE_RST = 32'h54455854;
	localparam int CFG_AW = 3;
	localparam int JOB_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	// job opcodes between front and back
	localparam logic [1:0] JOB_FEED = 2'd0;
	localparam logic [1:0] JOB_FAIL = 2'd1;
	localparam logic [1:0] JOB_RESTART = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_HDR = 2'd1;
	localparam logic [1:0] KIND_RUN = 2'd2;
	localparam logic [1:0] KIND_END = 2'd3;

	// end status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_CHAR = 3'd1;
	localparam logic [2:0] ST_COLON = 3'd2;
	localparam logic [2:0] ST_HDR_CRC = 3'd3;
	localparam logic [2:0] ST_DATA_CRC = 3'd4;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic [7:0] count;
		logic [2:0] status;
	} job_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic [7:0] repeat_count;
		logic expand_crlf;
		logic from_resource;
		logic [31:0] fork_length;
		logic [2:0] status;
		logic last;
	} res_t;

	// map one encoded character to its 6-bit value or a control code
	function automatic logic [7:0] map_char(input logic [7:0] c);
		logic [7:0] v;
		v = CODE_FAIL;
		if (c >= 8'h21 && c <= 8'h2D) v = c - 8'h21;
		else if (c >= 8'h30 && c <= 8'h36) v = c - 8'h30 + 8'h0D;
		else if (c >= 8'h38 && c <= 8'h39) v = c - 8'h38 + 8'h14;
		else if (c >= 8'h40 && c <= 8'h4E) v = c - 8'h40 + 8'h16;
		else if (c >= 8'h50 && c <= 8'h56) v = c - 8'h50 + 8'h25;
		else if (c >= 8'h58 && c <= 8'h5B) v = c - 8'h58 + 8'h2C;
		else if (c >= 8'h60 && c <= 8'h66) v = c - 8'h60 + 8'h30;
		else if (c >= 8'h68 && c <= 8'h6D) v = c - 8'h68 + 8'h37;
		else if (c >= 8'h70 && c <= 8'h72) v = c - 8'h70 + 8'h3D;
		else if (c == 8'h0A || c == 8'h0D) v = CODE_SKIP;
		else if (c == CHAR_COLON) v = CODE_DONE;
		return v;
	endfunction

	// shift one byte into the augmented CRC-16, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] t;
		logic top;
		t = crc;
		for (int i = 0; i < 8; i++) begin
			top = t[15];
			t = {t[14:0], b[7 - i]};
			if (top) t = t ^ CRC_POLY;
		end
		return t;
	endfunction

endpackage

@@ hw/rtl/bhx_fifo.sv @@
// Small register FIFO used for the job queue and the result queue.
module bhx_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bhx_pkg::JOB_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	// store the item
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end
endmodule

@@ hw/rtl/bhx_front.sv @@
// Front end: colon search, character mapping, sextet packing and run marks.
module bhx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_take,
	input  logic              cmd,
	input  logic [7:0]        char_in,
	output logic              job_we,
	output bhx_pkg::job_t     job_d
);
	logic wait_q, done_q, run_q;
	logic [1:0] sx_q;
	logic [7:0] part_q, lastb_q;

	logic wait_d, done_d, run_d;
	logic [1:0] sx_d;
	logic [7:0] part_d, lastb_d;
	logic [7:0] v, data;
	logic have;

	// classify the item and build a job
	always_comb begin
		wait_d = wait_q;
		done_d = done_q;
		run_d = run_q;
		sx_d = sx_q;
		part_d = part_q;
		lastb_d = lastb_q;
		job_we = 1'b0;
		job_d = '0;
		v = bhx_pkg::map_char(char_in);
		data = '0;
		have = 1'b0;
		if (in_take) begin
			if (cmd) begin
				wait_d = 1'b1;
				done_d = 1'b0;
				run_d = 1'b0;
				sx_d = '0;
				part_d = '0;
				lastb_d = '0;
				job_we = 1'b1;
				job_d.op = bhx_pkg::JOB_RESTART;
			end else if (wait_q) begin
				if (char_in == bhx_pkg::CHAR_COLON) wait_d = 1'b0;
			end else if (!done_q && v != bhx_pkg::CODE_SKIP) begin
				if (v == bhx_pkg::CODE_DONE || v == bhx_pkg::CODE_FAIL) begin
					done_d = 1'b1;
					job_we = 1'b1;
					job_d.op = bhx_pkg::JOB_FAIL;
					job_d.status = (v == bhx_pkg::CODE_DONE) ? bhx_pkg::ST_COLON
						: bhx_pkg::ST_BAD_CHAR;
				end else begin
					case (sx_q)
						2'd0: begin
							part_d = {v[5:0], 2'b00};
							sx_d = 2'd1;
						end
						2'd1: begin
							data = part_q | (v >> 4);
							part_d = {v[3:0], 4'b0};
							sx_d = 2'd2;
							have = 1'b1;
						end
						2'd2: begin
							data = part_q | (v >> 2);
							part_d = {v[1:0], 6'b0};
							sx_d = 2'd3;
							have = 1'b1;
						end
						default: begin
							data = part_q | v;
							sx_d = 2'd0;
							have = 1'b1;
						end
					endcase
					if (have) begin
						if (!run_q) begin
							if (data == bhx_pkg::RUN_MARK) run_d = 1'b1;
							else begin
								lastb_d = data;
								job_we = 1'b1;
								job_d.op = bhx_pkg::JOB_FEED;
								job_d.data = data;
								job_d.count = 8'd1;
							end
						end else begin
							run_d = 1'b0;
							if (data == 8'd0) begin
								lastb_d = bhx_pkg::RUN_MARK;
								job_we = 1'b1;
								job_d.op = bhx_pkg::JOB_FEED;
								job_d.data = bhx_pkg::RUN_MARK;
								job_d.count = 8'd1;
							end else if (data != 8'd1) begin
								job_we = 1'b1;
								job_d.op = bhx_pkg::JOB_FEED;
								job_d.data = lastb_q;
								job_d.count = data - 8'd1;
							end
						end
					end
				end
			end
		end
	end

	// hold front state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= 1'b1;
			done_q <= 1'b0;
			run_q <= 1'b0;
			sx_q <= '0;
			part_q <= '0;
			lastb_q <= '0;
		end else begin
			wait_q <= wait_d;
			done_q <= done_d;
			run_q <= run_d;
			sx_q <= sx_d;
			part_q <= part_d;
			lastb_q <= lastb_d;
		end
	end
endmodule

@@ hw/rtl/bhx_back.sv @@
// Back end: byte parser, CRC checks, run merging and result framing.
module bhx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       text_type,
	input  logic              job_empty,
	input  bhx_pkg::job_t     job,
	output logic              job_pop,
	input  logic              out_full,
	output logic              out_we,
	output bhx_pkg::res_t     out_d
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FEED = 3'd1;
	localparam logic [2:0] S_CHK1 = 3'd2;
	localparam logic [2:0] S_CHK2 = 3'd3;
	localparam logic [2:0] S_END = 3'd4;

	localparam logic [2:0] P_NAME = 3'd0;
	localparam logic [2:0] P_INFO = 3'd1;
	localparam logic [2:0] P_DATA = 3'd2;
	localparam logic [2:0] P_DCRC = 3'd3;
	localparam logic [2:0] P_RZ = 3'd4;
	localparam logic [2:0] P_RCRC = 3'd5;
	localparam logic [2:0] P_DONE = 3'd6;

	localparam int NW = $clog2(bhx_pkg::MAX_RES + 1);

	logic [2:0] st_q, st_d, ph_q, ph_d;
	logic [15:0] crc_q, crc_d, rx_q, rx_d;
	logic [4:0] idx_q, idx_d;
	logic [31:0] left_q, left_d, rlen_q, rlen_d;
	logic xlat_q, xlat_d, hdr_q, hdr_d;
	logic [7:0] cnt_q, cnt_d, byte_q, byte_d;
	bhx_pkg::res_t pend_q, pend_d;
	logic pv_q, pv_d;
	logic [NW-1:0] nout_q, nout_d;
	logic [7:0] info_q [bhx_pkg::INFO_LEN];
	logic info_we;
	logic [4:0] idx_next;
	logic [15:0] crc_z;
	logic crc_ok;

	logic adv;
	logic off_v, off_m;
	bhx_pkg::res_t off_r;
	logic [31:0] type_w, len_w, res_w;

	assign adv = !out_full;
	assign type_w = {info_q[0], info_q[1], info_q[2], info_q[3]};
	assign len_w = {info_q[10], info_q[11], info_q[12], info_q[13]};
	assign res_w = {info_q[14], info_q[15], info_q[16], info_q[17]};
	assign idx_next = idx_q + 5'd1;
	assign crc_z = bhx_pkg::crc_byte(crc_q, 8'h00);
	assign crc_ok = (crc_z == rx_q);

	// step the parser, one decoded byte or check step per cycle while the result queue has room
	always_comb begin
		st_d = st_q; ph_d = ph_q; crc_d = crc_q; rx_d = rx_q; idx_d = idx_q;
		left_d = left_q; rlen_d = rlen_q; xlat_d = xlat_q; hdr_d = hdr_q;
		cnt_d = cnt_q; byte_d = byte_q; pend_d = pend_q; pv_d = pv_q; nout_d = nout_q;
		job_pop = 1'b0;
		info_we = 1'b0;
		off_v = 1'b0;
		off_m = 1'b0;
		off_r = '0;
		out_we = 1'b0;
		out_d = pend_q;
		out_d.last = 1'b0;
		if (adv) begin
			case (st_q)
				S_IDLE: begin
					if (!job_empty) begin
						job_pop = 1'b1;
						case (job.op)
							bhx_pkg::JOB_RESTART: begin
								ph_d = P_NAME; crc_d = '0; rx_d = '0; idx_d = '0;
								left_d = '0; rlen_d = '0; xlat_d = 1'b0;
							end
							bhx_pkg::JOB_FAIL: begin
								if (ph_q != P_DONE) begin
									off_v = 1'b1;
									off_r.kind = bhx_pkg::KIND_END;
									off_r.status = job.status;
									ph_d = P_DONE;
								end
								st_d = S_END;
							end
							default: begin
								byte_d = job.data;
								cnt_d = job.count;
								st_d = S_FEED;
							end
						endcase
					end
				end
				S_FEED: begin
					if (cnt_q == 8'd0 || ph_q == P_DONE) st_d = S_END;
					else begin
						cnt_d = cnt_q - 8'd1;
						case (ph_q)
							P_NAME: begin
								crc_d = bhx_pkg::crc_byte(crc_q, byte_q);
								if (byte_q != 8'd0) begin
									off_v = 1'b1; off_m = 1'b1;
									off_r.kind = bhx_pkg::KIND_NAME;
									off_r.byte_value = byte_q;
									off_r.repeat_count = 8'd1;
								end else begin
									ph_d = P_INFO;
									idx_d = '0;
								end
							end
							P_INFO: begin
								info_we = (idx_q < 5'(bhx_pkg::INFO_LEN));
								idx_d = idx_next;
								if (idx_next <= 5'd18) crc_d = bhx_pkg::crc_byte(crc_q, byte_q);
								if (idx_next >= 5'(bhx_pkg::INFO_LEN)) begin
									rx_d = {info_q[18], byte_q};
									hdr_d = 1'b1;
									st_d = S_CHK1;
								end
							end
							P_DATA, P_RZ: begin
								if (left_q != '0) begin
									off_v = 1'b1; off_m = 1'b1;
									off_r.kind = bhx_pkg::KIND_RUN;
									off_r.byte_value = byte_q;
									off_r.repeat_count = 8'd1;
									off_r.from_resource = (ph_q == P_RZ);
									off_r.expand_crlf = xlat_q && (byte_q == bhx_pkg::CHAR_CR);
									crc_d = bhx_pkg::crc_byte(crc_q, byte_q);
									left_d = left_q - 32'd1;
								end else begin
									rx_d = {byte_q, 8'h00};
									ph_d = (ph_q == P_DATA) ? P_DCRC : P_RCRC;
								end
							end
							P_DCRC, P_RCRC: begin
								rx_d = {rx_q[15:8], byte_q};
								hdr_d = 1'b0;
								st_d = S_CHK1;
							end
							default: ;
						endcase
					end
				end
				S_CHK1: begin
					crc_d = crc_z;
					st_d = S_CHK2;
				end
				S_CHK2: begin
					crc_d = '0;
					st_d = S_FEED;
					if (!crc_ok) begin
						off_v = 1'b1;
						off_r.kind = bhx_pkg::KIND_END;
						off_r.status = hdr_q ? bhx_pkg::ST_HDR_CRC : bhx_pkg::ST_DATA_CRC;
						ph_d = P_DONE;
					end else if (hdr_q) begin
						xlat_d = (type_w == text_type);
						left_d = len_w;
						rlen_d = res_w;
						off_v = 1'b1;
						off_r.kind = bhx_pkg::KIND_HDR;
						off_r.expand_crlf = (type_w == text_type);
						off_r.fork_length = len_w;
						ph_d = P_DATA;
					end else if (ph_q == P_DCRC && len_w == '0) begin
						left_d = rlen_q;
						ph_d = P_RZ;
					end else begin
						off_v = 1'b1;
						off_r.kind = bhx_pkg::KIND_END;
						off_r.status = bhx_pkg::ST_OK;
						ph_d = P_DONE;
					end
				end
				S_END: begin
					if (pv_q) begin
						out_we = 1'b1;
						out_d.last = 1'b1;
					end
					pv_d = 1'b0;
					nout_d = '0;
					st_d = S_IDLE;
				end
				default: st_d = S_IDLE;
			endcase

			// merge into the pending result, or flush it and start a new one, up to MAX_RES per job
			if (off_v) begin
				if (off_m && pv_q && pend_q.kind == off_r.kind &&
					pend_q.byte_value == off_r.byte_value &&
					pend_q.from_resource == off_r.from_resource &&
					pend_q.repeat_count != 8'd255) begin
					pend_d.repeat_count = pend_q.repeat_count + 8'd1;
				end else if (nout_q < NW'(bhx_pkg::MAX_RES)) begin
					out_we = pv_q;
					pend_d = off_r;
					pv_d = 1'b1;
					nout_d = nout_q + 1'b1;
				end
			end
		end
	end

	// hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ph_q <= P_NAME; crc_q <= '0; rx_q <= '0; idx_q <= '0;
			left_q <= '0; rlen_q <= '0; xlat_q <= 1'b0; hdr_q <= 1'b0;
			cnt_q <= '0; pv_q <= 1'b0; nout_q <= '0;
		end else begin
			st_q <= st_d; ph_q <= ph_d; crc_q <= crc_d; rx_q <= rx_d; idx_q <= idx_d;
			left_q <= left_d; rlen_q <= rlen_d; xlat_q <= xlat_d; hdr_q <= hdr_d;
			cnt_q <= cnt_d; pv_q <= pv_d; nout_q <= nout_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		pend_q <= pend_d;
		if (adv && info_we) info_q[idx_q] <= byte_q;
	end
endmodule

@@ hw/rtl/binhex4_stream_decoder.sv @@
// Top level of the BinHex 4.0 stream decoder: config register, queues, front and back.
// An item passes through the front, the job queue, the back and the result queue before
// its results reach the result ports; a CRC check adds the S_CHK1 and S_CHK2 steps.
// Throughput: the front takes one item per cycle while the job queue has room; the back
// takes one job at a time and stalls while the result queue is full.
// Reset (arst_n low) clears all control state and sets the text type to "TEXT".
module binhex4_stream_decoder #(
	parameter int JOB_DEPTH = bhx_pkg::JOB_DEPTH,
	parameter int RES_DEPTH = bhx_pkg::RES_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     cmd,
	input  logic [7:0]               char_in,
	output logic                     empty,
	input  logic                     pop,
	output logic [1:0]               kind,
	output logic [7:0]               byte_value,
	output logic [7:0]               repeat_count,
	output logic                     expand_crlf,
	output logic                     from_resource,
	output logic [31:0]              fork_length,
	output logic [2:0]               status,
	output logic                     last,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [bhx_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	logic [31:0] type_q;
	logic job_we, job_full, job_empty, job_pop, res_we, res_full;
	bhx_pkg::job_t job_wd, job_rd;
	bhx_pkg::res_t res_wd, res_rd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? type_q : '0;
	assign full = job_full;

	// write the text type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) type_q <= bhx_pkg::TEXT_TYPE_RST;
		else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) type_q <= pwdata;
	end

	bhx_front u_front (
		.clk(clk), .arst_n(arst_n), .in_take(push && !job_full),
		.cmd(cmd), .char_in(char_in), .job_we(job_we), .job_d(job_wd)
	);

	bhx_fifo #(.WIDTH($bits(bhx_pkg::job_t)), .DEPTH(JOB_DEPTH)) u_jobq (
		.clk(clk), .arst_n(arst_n), .wr_en(job_we), .wr_data(job_wd), .full(job_full),
		.rd_en(job_pop), .rd_data(job_rd), .empty(job_empty)
	);

	bhx_back u_back (
		.clk(clk), .arst_n(arst_n), .text_type(type_q), .job_empty(job_empty),
		.job(job_rd), .job_pop(job_pop), .out_full(res_full), .out_we(res_we),
		.out_d(res_wd)
	);

	bhx_fifo #(.WIDTH($bits(bhx_pkg::res_t)), .DEPTH(RES_DEPTH)) u_resq (
		.clk(clk), .arst_n(arst_n), .wr_en(res_we), .wr_data(res_wd), .full(res_full),
		.rd_en(pop), .rd_data(res_rd), .empty(empty)
	);

	assign kind = res_rd.kind;
	assign byte_value = res_rd.byte_value;
	assign repeat_count = res_rd.repeat_count;
	assign expand_crlf = res_rd.expand_crlf;
	assign from_resource = res_rd.from_resource;
	assign fork_length = res_rd.fork_length;
	assign status = res_rd.status;
	assign last = res_rd.last;
endmodule

@@ hw/rtl/bhx_checker.sv @@
// Port-level checks of the decoder's result stream, bound to the top level.
module bhx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] kind,
	input logic [7:0] byte_value,
	input logic [7:0] repeat_count,
	input logic       expand_crlf,
	input logic [31:0] fork_length,
	input logic [2:0] status
);
	// hold a waiting item until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(kind) && $stable(byte_value))
		else $error("result changed while stalled");

	// name and run items carry a count and no status
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == bhx_pkg::KIND_NAME || kind == bhx_pkg::KIND_RUN) |->
		repeat_count != 8'd0 && status == bhx_pkg::ST_OK && fork_length == '0)
		else $error("bad byte item");

	// end items carry no byte
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == bhx_pkg::KIND_END |-> repeat_count == 8'd0 && byte_value == 8'd0)
		else $error("bad end item");

	// line end expansion only on carriage return runs
	a_crlf: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == bhx_pkg::KIND_RUN && expand_crlf |-> byte_value == bhx_pkg::CHAR_CR)
		else $error("expansion on wrong byte");
endmodule

bind binhex4_stream_decoder bhx_checker u_bhx_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .kind(kind),
	.byte_value(byte_value), .repeat_count(repeat_count), .expand_crlf(expand_crlf),
	.fork_length(fork_length), .status(status)
);
